// ----- design/drq_pkg.sv -----
// shared types and constants for the deadline request queue
`timescale 1ns / 1ps
package drq_pkg;
    localparam int Capacity = 16;
    localparam int SlotW = $clog2(Capacity);
    localparam int DepthW = 5;
    localparam logic [63:0] NsPerSecond = 64'd1000000000;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_POP    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_UNVERIFY = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // one table entry as held in memory
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] deadline;
        logic [7:0]  prio;
    } t_entry;
endpackage

// ----- design/deadline_request_queue.sv -----
// top level: request table with earliest-deadline-first pop
`timescale 1ns / 1ps
// Deadline request queue. One word in on the i_ channel (valid/ready), one
// result word out on the o_ channel. Entry payload lives in a 16-entry
// synchronous memory with a registered read; valid bits and arrival
// ranks are kept in flip-flops.
// Steps from the taking of a word to the loading of its result into the
// output register:
//   submit with rate and no deadline: divider start and a 30-bit quotient,
//     then done check, 30x32 multiply, 64-bit add and output load
//   other submits and the unused mode: output load
//   cancel and pop: one memory read per slot, judging of the last read,
//     removal of the chosen entry and output load
// One word is worked on at a time; the next is taken as soon as the
// previous result is loaded into the output register. While the receiver
// stalls, a finished result waits in the working registers until the
// output register frees, and no new word is taken meanwhile.
// Reset (synchronous, active low) empties the table, sets the next id to
// one and clears the output valid; no clearing pass is needed.
module deadline_request_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_now_ns,
    input  logic [63:0] i_deadline_ns,
    input  logic [31:0] i_target_rate,
    input  logic [31:0] i_max_tokens,
    input  logic [7:0]  i_priority_req,
    input  logic        i_model_verified,
    input  logic [31:0] i_request_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_result_id,
    output logic [63:0] o_result_deadline,
    output logic [7:0]  o_result_priority,
    output logic [4:0]  o_entry_count
);
    import drq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_ADD, S_SCAN, S_DONE, S_EMIT
    } t_state;

    t_state r_state;
    t_entry r_mem [Capacity];
    t_entry r_rd;
    t_entry w_wr;
    logic        w_we;
    logic [SlotW-1:0] w_waddr;
    logic [SlotW-1:0] w_raddr;

    logic [Capacity-1:0] r_valid;
    logic [SlotW-1:0]    r_rank [Capacity];
    logic [31:0]  r_next_id;
    logic [DepthW-1:0] r_depth;

    // latched request
    logic [1:0]  r_mode;
    logic [63:0] r_now;
    logic [31:0] r_tok;
    logic [7:0]  r_prio;
    logic [31:0] r_req;
    logic [SlotW-1:0] r_free;

    // scan
    logic [SlotW:0]   r_idx;
    logic             r_rd_ok;
    logic [SlotW-1:0] r_rd_slot;
    logic             r_found;
    logic [SlotW-1:0] r_best;
    t_entry           r_best_e;

    logic [63:0] r_prod;
    logic        w_div_start;
    logic        w_div_done;
    logic [29:0] w_quot;

    // working result
    logic [2:0]  r_ostat;
    logic [31:0] r_oid;
    logic [63:0] r_odl;
    logic [7:0]  r_oprio;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_out_stat;
    logic [31:0] r_out_id;
    logic [63:0] r_out_dl;
    logic [7:0]  r_out_prio;
    logic [4:0]  r_out_count;
    logic        w_load;

    drq_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_divisor(r_req),
        .o_done   (w_div_done),
        .o_quot   (w_quot)
    );

    // memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wr;
        r_rd <= r_mem[w_raddr];
    end

    assign w_raddr = r_idx[SlotW-1:0];

    // lowest free slot
    logic [SlotW-1:0] w_free;
    logic             w_full;
    always_comb begin
        w_free = '0;
        w_full = 1'b1;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = SlotW'(i);
                w_full = 1'b0;
            end
        end
    end

    // does the candidate just read beat the running best
    logic w_beats;
    logic w_ca, w_cb;
    always_comb begin
        w_ca = r_rd.deadline != '0;
        w_cb = r_best_e.deadline != '0;
        if (!r_found) w_beats = 1'b1;
        else if (r_mode == MODE_CANCEL)
            w_beats = r_rank[r_rd_slot] < r_rank[r_best];
        else if (w_ca != w_cb) w_beats = w_ca;
        else if (w_ca && r_rd.deadline != r_best_e.deadline)
            w_beats = r_rd.deadline < r_best_e.deadline;
        else if (!w_ca && r_rd.prio != r_best_e.prio)
            w_beats = r_rd.prio < r_best_e.prio;
        else
            w_beats = r_rank[r_rd_slot] < r_rank[r_best];
    end

    logic w_cand;
    assign w_cand = r_rd_ok && r_valid[r_rd_slot] &&
                    (r_mode != MODE_CANCEL || r_rd.id == r_req);

    assign w_we    = (r_state == S_ADD) || (r_state == S_IDLE && i_valid && o_ready
                     && i_mode == MODE_SUBMIT && i_model_verified && !w_full
                     && !(i_deadline_ns == '0 && i_target_rate != '0));
    assign w_waddr = (r_state == S_IDLE) ? w_free : r_free;
    always_comb begin
        w_wr.id = r_next_id;
        if (r_state == S_IDLE) begin
            w_wr.deadline = i_deadline_ns;
            w_wr.prio     = i_priority_req;
        end else begin
            w_wr.deadline = r_now + r_prod;
            w_wr.prio     = r_prio;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign w_div_start = (r_state == S_DIV) && (r_idx == '0);
    // finished result moves out once the output register is free
    assign w_load = (r_state == S_EMIT) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_next_id <= 32'd1;
            r_depth   <= '0;
            r_ovalid  <= 1'b0;
            r_idx     <= '0;
            r_rd_ok   <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode <= i_mode;
                        r_now  <= i_now_ns;
                        r_tok  <= (i_max_tokens == '0) ? 32'd1 : i_max_tokens;
                        r_prio <= i_priority_req;
                        r_req  <= (i_mode == MODE_SUBMIT) ? i_target_rate
                                                          : i_request_id;
                        r_free <= w_free;
                        r_idx  <= '0;
                        r_found <= 1'b0;
                        r_oprio <= '0;
                        r_oid   <= '0;
                        r_odl   <= '0;
                        r_ostat <= ST_INVALID;
                        case (t_mode'(i_mode))
                            MODE_SUBMIT: begin
                                if (!i_model_verified) begin
                                    r_ostat   <= ST_UNVERIFY;
                                    r_oid     <= r_next_id;
                                    r_next_id <= r_next_id + 32'd1;
                                    r_state   <= S_EMIT;
                                end else if (w_full) begin
                                    r_ostat <= ST_FULL;
                                    r_state <= S_EMIT;
                                end else if (i_deadline_ns == '0 &&
                                             i_target_rate != '0) begin
                                    r_state <= S_DIV;
                                end else begin
                                    r_valid[w_free] <= 1'b1;
                                    r_rank[w_free]  <= r_depth[SlotW-1:0];
                                    r_depth   <= r_depth + DepthW'(1);
                                    r_ostat   <= ST_OK;
                                    r_oid     <= r_next_id;
                                    r_odl     <= i_deadline_ns;
                                    r_oprio   <= i_priority_req;
                                    r_next_id <= r_next_id + 32'd1;
                                    r_state   <= S_EMIT;
                                end
                            end
                            MODE_CANCEL, MODE_POP: r_state <= S_SCAN;
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_DIV: begin
                    r_idx <= (SlotW+1)'(1);
                    if (w_div_done) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= {34'd0, w_quot} * {32'd0, r_tok};
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_valid[r_free] <= 1'b1;
                    r_rank[r_free]  <= r_depth[SlotW-1:0];
                    r_depth   <= r_depth + DepthW'(1);
                    r_ostat   <= ST_OK;
                    r_oid     <= r_next_id;
                    r_odl     <= w_wr.deadline;
                    r_oprio   <= r_prio;
                    r_next_id <= r_next_id + 32'd1;
                    r_state   <= S_EMIT;
                end
                S_SCAN: begin
                    // issue read at r_idx, judge the word read last cycle
                    if (r_idx != (SlotW+1)'(Capacity)) begin
                        r_rd_slot <= r_idx[SlotW-1:0];
                        r_idx     <= r_idx + (SlotW+1)'(1);
                    end
                    r_rd_ok <= (r_idx != (SlotW+1)'(Capacity));
                    if (w_cand && w_beats) begin
                        r_found  <= 1'b1;
                        r_best   <= r_rd_slot;
                        r_best_e <= r_rd;
                    end
                    if (r_idx == (SlotW+1)'(Capacity) && !r_rd_ok)
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_found) begin
                        for (int i = 0; i < Capacity; i++)
                            if (r_valid[i] && r_rank[i] > r_rank[r_best])
                                r_rank[i] <= r_rank[i] - SlotW'(1);
                        r_valid[r_best] <= 1'b0;
                        r_depth <= r_depth - DepthW'(1);
                        r_ostat <= ST_OK;
                        r_oid   <= r_best_e.id;
                        r_odl   <= r_best_e.deadline;
                        r_oprio <= r_best_e.prio;
                    end else begin
                        r_ostat <= (r_mode == MODE_POP) ? ST_EMPTY : ST_INVALID;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_stat  <= r_ostat;
                        r_out_id    <= r_oid;
                        r_out_dl    <= r_odl;
                        r_out_prio  <= r_oprio;
                        r_out_count <= r_depth;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_out_stat;
    assign o_result_id       = r_out_id;
    assign o_result_deadline = r_out_dl;
    assign o_result_priority = r_out_prio;
    assign o_entry_count     = r_out_count;
endmodule

// ----- design/drq_div.sv -----
// restoring divider for 1e9 / rate, one quotient bit a cycle
`timescale 1ns / 1ps
module drq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [29:0] o_quot
);
    import drq_pkg::*;

    logic [29:0] r_num;
    logic [29:0] r_quot;
    logic [31:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_num[29]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= NsPerSecond[29:0];
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= 5'd29;
            end else if (r_busy) begin
                r_num <= {r_num[28:0], 1'b0};
                if (!w_diff[32]) begin
                    r_rem  <= w_diff[31:0];
                    r_quot <= {r_quot[28:0], 1'b1};
                end else begin
                    r_rem  <= w_trial[31:0];
                    r_quot <= {r_quot[28:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- test/deadline_request_queue_test.sv -----
// self-checking testbench for the deadline request queue
`timescale 1ns / 1ps
module deadline_request_queue_test;
    import drq_pkg::*;

    typedef struct {
        t_status     status;
        logic [31:0] id;
        logic [63:0] deadline;
        logic [7:0]  prio;
        logic [4:0]  depth;
    } t_outcome;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // table mirror plus queue of expected results
    class edf_scoreboard;
        bit          slot_used[Capacity];
        logic [31:0] slot_id[Capacity];
        logic [63:0] slot_deadline[Capacity];
        logic [7:0]  slot_prio[Capacity];
        int unsigned slot_rank[Capacity];
        logic [31:0] id_counter;
        int unsigned depth;
        t_outcome    pending[$];
        int          results_seen;

        function new();
            id_counter = 32'd1;
            depth = 0;
            results_seen = 0;
            foreach (slot_used[i]) slot_used[i] = 0;
        endfunction

        function bit served_first(int a, int b);
            bit a_has, b_has;
            a_has = slot_deadline[a] != 0;
            b_has = slot_deadline[b] != 0;
            if (a_has != b_has) return a_has;
            if (a_has && slot_deadline[a] != slot_deadline[b])
                return slot_deadline[a] < slot_deadline[b];
            if (!a_has && slot_prio[a] != slot_prio[b])
                return slot_prio[a] < slot_prio[b];
            return slot_rank[a] < slot_rank[b];
        endfunction

        function void drop_slot(int s);
            for (int i = 0; i < Capacity; i++)
                if (slot_used[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
            slot_used[s] = 0;
            if (depth != 0) depth--;
        endfunction

        function void note_word(t_mode mode, logic [63:0] now, logic [63:0] dl,
                                logic [31:0] rate, logic [31:0] tokens,
                                logic [7:0] prio, bit verified, logic [31:0] req);
            t_outcome o;
            int pick;
            logic [63:0] tok;
            o.status = ST_INVALID; o.id = 0; o.deadline = 0; o.prio = 0;
            pick = -1;
            case (mode)
                MODE_SUBMIT: begin
                    for (int i = Capacity - 1; i >= 0; i--)
                        if (!slot_used[i]) pick = i;
                    if (!verified) begin
                        o.id = id_counter; id_counter++; o.status = ST_UNVERIFY;
                    end else if (pick < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        if (dl == 0 && rate != 0) begin
                            tok = (tokens != 0) ? {32'd0, tokens} : 64'd1;
                            dl = now + (NsPerSecond / {32'd0, rate}) * tok;
                        end
                        slot_used[pick] = 1; slot_id[pick] = id_counter;
                        slot_deadline[pick] = dl; slot_prio[pick] = prio;
                        slot_rank[pick] = depth; depth++;
                        o.id = id_counter; id_counter++;
                        o.deadline = dl; o.prio = prio; o.status = ST_OK;
                    end
                end
                MODE_CANCEL, MODE_POP: begin
                    for (int i = 0; i < Capacity; i++) begin
                        if (!slot_used[i]) continue;
                        if (mode == MODE_CANCEL) begin
                            if (slot_id[i] == req &&
                                (pick < 0 || slot_rank[i] < slot_rank[pick])) pick = i;
                        end else if (pick < 0 || served_first(i, pick)) pick = i;
                    end
                    if (pick < 0) begin
                        o.status = (mode == MODE_POP) ? ST_EMPTY : ST_INVALID;
                    end else begin
                        o.id = slot_id[pick]; o.deadline = slot_deadline[pick];
                        o.prio = slot_prio[pick]; drop_slot(pick); o.status = ST_OK;
                    end
                end
                default: ;
            endcase
            o.depth = depth[4:0];
            pending.push_back(o);
        endfunction

        task check_result(logic [2:0] st, logic [31:0] id, logic [63:0] dl,
                          logic [7:0] prio, logic [4:0] dep);
            t_outcome w;
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(st), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (st !== w.status) report_mismatch("status", 64'(st), 64'(w.status));
            if (id !== w.id) report_mismatch("result_id", 64'(id), 64'(w.id));
            if (dl !== w.deadline) report_mismatch("result_deadline", dl, w.deadline);
            if (prio !== w.prio)
                report_mismatch("result_priority", 64'(prio), 64'(w.prio));
            if (dep !== w.depth) report_mismatch("entry_count", 64'(dep), 64'(w.depth));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_mode = MODE_SUBMIT;
    logic [63:0] i_now_ns = 0;
    logic [63:0] i_deadline_ns = 0;
    logic [31:0] i_target_rate = 0;
    logic [31:0] i_max_tokens = 0;
    logic [7:0]  i_priority_req = 0;
    logic        i_model_verified = 0;
    logic [31:0] i_request_id = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_status;
    logic [31:0] o_result_id;
    logic [63:0] o_result_deadline;
    logic [7:0]  o_result_priority;
    logic [4:0]  o_entry_count;

    deadline_request_queue u_dut (.*);

    always #5 i_clk = ~i_clk;

    edf_scoreboard board = new();
    bit calm = 0;           // no idling on either side while set
    int idle_cycles = 0;
    int word_count = 0;

    // sample on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_word(t_mode'(i_mode), i_now_ns, i_deadline_ns, i_target_rate,
                                i_max_tokens, i_priority_req, i_model_verified,
                                i_request_id);
                word_count++;
            end
            if (o_valid && i_ready) begin
                board.check_result(o_status, o_result_id, o_result_deadline,
                                   o_result_priority, o_entry_count);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("deadline_request_queue regression: fail");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 16);

    // returns right after the accepting edge with valid still high
    task automatic send_word(input t_mode mode, input logic [63:0] now,
                             input logic [63:0] dl, input logic [31:0] rate,
                             input logic [31:0] tokens, input logic [7:0] prio,
                             input bit verified, input logic [31:0] req);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 16) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_mode <= mode; i_now_ns <= now; i_deadline_ns <= dl; i_target_rate <= rate;
        i_max_tokens <= tokens; i_priority_req <= prio; i_model_verified <= verified;
        i_request_id <= req; i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random submit: mostly small rates and times so deadlines interleave
    task automatic random_submit();
        logic [63:0] now, dl;
        logic [31:0] rate, tokens;
        case ($urandom_range(5))
            0: begin dl = 0; rate = 0; end
            1: begin dl = 64'($urandom_range(40)); rate = 0; end
            2: begin dl = 0; rate = $urandom_range(1, 20); end
            3: begin dl = rand64(); rate = $urandom(); end
            4: begin dl = 0; rate = $urandom(); end
            default: begin dl = 64'($urandom_range(1, 3)); rate = $urandom_range(3); end
        endcase
        now = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(1000));
        tokens = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3);
        send_word(MODE_SUBMIT, now, dl, rate, tokens,
                  ($urandom_range(1) ? 8'($urandom()) : 8'($urandom_range(3))),
                  $urandom_range(15) != 0, $urandom());
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty table, unused mode, unknown cancel
        send_word(MODE_POP, 0, 0, 0, 0, 0, 1, 0);
        send_word(MODE_NONE, rand64(), rand64(), '1, '1, '1, 1, '1);
        send_word(MODE_CANCEL, 0, 0, 0, 0, 0, 1, 32'd1);
        send_word(MODE_SUBMIT, 0, 0, 0, 0, 8'd5, 0, 0);                  // unverified
        send_word(MODE_SUBMIT, '1, 0, 32'd1, '1, 8'd0, 1, 0);              // rate, big tokens
        send_word(MODE_SUBMIT, 64'd100, 0, '1, 0, 8'hff, 1, 0);            // tokens zero
        send_word(MODE_SUBMIT, 64'hFFFF_FFFF_C465_3600, 0, 32'd1, 32'd1, 8'd7, 1, 0); // wraps to 0
        send_word(MODE_SUBMIT, 0, '1, '1, '1, 8'd3, 1, '1);
        send_word(MODE_SUBMIT, 0, 64'd1, 0, 0, 8'd0, 1, 0);
        send_word(MODE_SUBMIT, 0, 0, 0, 0, 8'd7, 1, 0);                    // priority tie
        for (int i = 0; i < 12; i++)                                        // fill past full
            send_word(MODE_SUBMIT, 0, 0, 0, 0, 8'($urandom()), 1, 0);
        send_word(MODE_CANCEL, 0, 0, 0, 0, 0, 1, 32'd4);
        for (int i = 0; i < 17; i++) send_word(MODE_POP, 0, 0, 0, 0, 0, 1, 0);
        drain();    // sender holds off until all results are back

        for (int n = 0; n < 1500; n++) begin
            calm = (n >= 600 && n < 800);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: random_submit();
                5, 6: send_word(MODE_CANCEL, 0, 0, 0, 0, 0, 1,
                                ($urandom_range(7) == 0) ? $urandom()
                                : board.id_counter - $urandom_range(1, 20));
                7, 8: send_word(MODE_POP, rand64(), rand64(), $urandom(), $urandom(),
                                8'($urandom()), 1'($urandom()), $urandom());
                default: send_word(($urandom_range(3) == 0) ? MODE_NONE : MODE_POP,
                                   0, 0, 0, 0, 0, 1, $urandom());
            endcase
            if (n == 900) drain();
        end
        calm = 0;
        drain();

        $display("covered %0d words through submit, cancel, pop and the unused mode,",
                 word_count);
        $display("with full, empty, unverified and wrapped-deadline cases");
        if (error_count == 0 && board.pending.size() == 0) begin
            $display("deadline_request_queue regression: pass");
        end else begin
            $display("deadline_request_queue regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/drq_pkg.sv
design/drq_div.sv
design/deadline_request_queue.sv
test/deadline_request_queue_test.sv
